// ===== design/sgm_pkg.sv =====
// Shared types and constants for the Sobel gradient magnitude block.
`timescale 1ns / 1ps
package sgm_pkg;
  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned CfgW = 12;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;
  localparam logic [CfgW-1:0] WidthReset = 12'd640;
  localparam logic [CfgW-1:0] HeightReset = 12'd480;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic signed [8:0] grad_x_blue;
    logic signed [8:0] grad_x_green;
    logic signed [8:0] grad_x_red;
    logic signed [8:0] grad_y_blue;
    logic signed [8:0] grad_y_green;
    logic signed [8:0] grad_y_red;
    logic [7:0] mag_blue;
    logic [7:0] mag_green;
    logic [7:0] mag_red;
    logic frame_last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the accepted pixel and read the line buffers
    logic shift;      // shift the window and write back the line buffers
    logic sqrt_start; // start the root iteration
    logic sqrt_step;  // one root bit
    logic emit;       // result is for an interior pixel
    logic last;       // final interior pixel of the frame
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } dp_sts_t;
endpackage

// ===== design/sgm_if.sv =====
// Valid/ready stream interfaces for pixels and results.
`timescale 1ns / 1ps
interface sgm_pix_if;
  logic valid;
  logic ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  modport source(output valid, blue, green, red, input ready);
  modport sink(input valid, blue, green, red, output ready);
endinterface

interface sgm_res_if;
  logic valid;
  logic ready;
  logic signed [8:0] grad_x_blue;
  logic signed [8:0] grad_x_green;
  logic signed [8:0] grad_x_red;
  logic signed [8:0] grad_y_blue;
  logic signed [8:0] grad_y_green;
  logic signed [8:0] grad_y_red;
  logic [7:0] mag_blue;
  logic [7:0] mag_green;
  logic [7:0] mag_red;
  logic frame_last;
  modport source(output valid, grad_x_blue, grad_x_green, grad_x_red, grad_y_blue,
    grad_y_green, grad_y_red, mag_blue, mag_green, mag_red, frame_last, input ready);
  modport sink(input valid, grad_x_blue, grad_x_green, grad_x_red, grad_y_blue,
    grad_y_green, grad_y_red, mag_blue, mag_green, mag_red, frame_last, output ready);
endinterface

// ===== design/sgm_datapath.sv =====
// Line buffers, 3x3 window, gradient arithmetic and shared bit-serial root.
`timescale 1ns / 1ps
module sgm_datapath #(
  parameter int unsigned MAX_WIDTH = sgm_pkg::MaxWidth,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sgm_pkg::dp_cmd_t cmd_i,
  input  logic [AW-1:0]    addr_i,
  input  sgm_pkg::pix_t    pix_i,
  output sgm_pkg::dp_sts_t sts_o,
  output sgm_pkg::res_t    res_o
);
  import sgm_pkg::*;

  pix_t lb_up_mem [MAX_WIDTH];
  pix_t lb_mid_mem [MAX_WIDTH];
  pix_t up_q, mid_q, cur_q;
  logic [AW-1:0] addr_q;
  pix_t win_q [3][3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      up_q   <= lb_up_mem[addr_i];
      mid_q  <= lb_mid_mem[addr_i];
      cur_q  <= pix_i;
      addr_q <= addr_i;
    end
    if (cmd_i.shift) begin
      lb_up_mem[addr_q]  <= mid_q;
      lb_mid_mem[addr_q] <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (cmd_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= up_q;
      win_q[1][2] <= mid_q;
      win_q[2][2] <= cur_q;
    end
  end

  // Per-channel gradients over the window; channel 0 is blue.
  logic signed [8:0] qx [3];
  logic signed [8:0] qy [3];
  always_comb begin
    logic signed [11:0] gx, gy;
    logic [7:0] a [3][3];
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          a[r][c] = (k == 0) ? win_q[r][c].blue :
                    (k == 1) ? win_q[r][c].green : win_q[r][c].red;
        end
      end
      gx = $signed({4'd0, a[0][0]}) - $signed({4'd0, a[0][2]})
         + 12'sd2 * ($signed({4'd0, a[1][0]}) - $signed({4'd0, a[1][2]}))
         + $signed({4'd0, a[2][0]}) - $signed({4'd0, a[2][2]});
      gy = $signed({4'd0, a[2][0]}) - $signed({4'd0, a[0][0]})
         + 12'sd2 * ($signed({4'd0, a[2][1]}) - $signed({4'd0, a[0][1]}))
         + $signed({4'd0, a[2][2]}) - $signed({4'd0, a[0][2]});
      // Divide by four, truncating toward zero.
      qx[k] = 9'((gx + (gx[11] ? 12'sd3 : 12'sd0)) >>> 2);
      qy[k] = 9'((gy + (gy[11] ? 12'sd3 : 12'sd0)) >>> 2);
    end
  end

  // Gradients are latched at sqrt_start; the sum of squares goes through
  // three 16-bit roots, one bit per cycle for all channels in parallel.
  logic signed [8:0] qx_q [3];
  logic signed [8:0] qy_q [3];
  logic [17:0] sum_q [3];
  logic [7:0] root_q [3];
  logic [7:0] bit_q;
  logic sat_d [3];
  logic sat_q [3];
  logic [3:0] bitcnt_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sat_d[k] = sum_q[k] >= 18'd65536;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q    <= '0;
      bitcnt_q <= '0;
    end else if (cmd_i.sqrt_start) begin
      bit_q    <= 8'h80;
      bitcnt_q <= 4'd9;
    end else if (cmd_i.sqrt_step && bitcnt_q != 4'd0) begin
      if (bitcnt_q != 4'd9) bit_q <= bit_q >> 1;
      bitcnt_q <= bitcnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [7:0] t;
    if (cmd_i.sqrt_start) begin
      for (int k = 0; k < 3; k++) begin
        qx_q[k]   <= qx[k];
        qy_q[k]   <= qy[k];
        sum_q[k]  <= 18'(qx[k] * qx[k]) + 18'(qy[k] * qy[k]);
        root_q[k] <= '0;
      end
    end else if (cmd_i.sqrt_step && bitcnt_q == 4'd9) begin
      for (int k = 0; k < 3; k++) sat_q[k] <= sat_d[k];
    end else if (cmd_i.sqrt_step && bitcnt_q != 4'd0) begin
      for (int k = 0; k < 3; k++) begin
        t = root_q[k] | bit_q;
        if ({2'b0, 16'(t * t)} <= sum_q[k]) root_q[k] <= t;
      end
    end
  end

  assign sts_o.sqrt_done = (bitcnt_q == 4'd0);

  always_comb begin
    res_o.grad_x_blue  = qx_q[0];
    res_o.grad_x_green = qx_q[1];
    res_o.grad_x_red   = qx_q[2];
    res_o.grad_y_blue  = qy_q[0];
    res_o.grad_y_green = qy_q[1];
    res_o.grad_y_red   = qy_q[2];
    res_o.mag_blue     = sat_q[0] ? 8'hFF : root_q[0];
    res_o.mag_green    = sat_q[1] ? 8'hFF : root_q[1];
    res_o.mag_red      = sat_q[2] ? 8'hFF : root_q[2];
    res_o.frame_last   = cmd_i.last;
  end
endmodule

// ===== design/sgm_ctrl.sv =====
// Sequencer: handshakes, raster counters and datapath commands.
`timescale 1ns / 1ps
module sgm_ctrl #(
  parameter int unsigned MAX_WIDTH = sgm_pkg::MaxWidth,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [sgm_pkg::CfgW-1:0] width_i,
  input  logic [sgm_pkg::CfgW-1:0] height_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [AW-1:0]           addr_o,
  output sgm_pkg::dp_cmd_t        cmd_o,
  input  sgm_pkg::dp_sts_t        sts_i
);
  import sgm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_START = 5'b00100,
    S_ROOT  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [12:0] col_q, row_q;
  logic emit_q, last_q, emit_d, last_d;
  logic [13:0] w_eff, h_eff;
  logic last_col, last_row;

  always_comb begin
    w_eff = {2'b0, width_i};
    if (w_eff < 14'd3) w_eff = 14'd3;
    if (w_eff > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
    h_eff = {2'b0, height_i};
    if (h_eff < 14'd3) h_eff = 14'd3;
  end

  assign last_col = {1'b0, col_q} >= w_eff - 14'd1;
  assign last_row = {1'b0, row_q} >= h_eff - 14'd1;
  assign addr_o = col_q[AW-1:0];
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign emit_d = row_q >= 13'd2 && col_q >= 13'd2;
  assign last_d = last_col && last_row;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.emit = emit_q;
    cmd_o.last = last_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d = emit_q ? S_START : S_IDLE;
      end
      S_START: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      emit_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_valid_i) begin
        emit_q <= emit_d;
        last_q <= last_d;
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? 13'd0 : row_q + 13'd1;
        end else begin
          col_q <= col_q + 13'd1;
        end
      end
    end
  end
endmodule

// ===== design/sobel_gradient_magnitude_3x3.sv =====
// Sobel 3x3 gradient and magnitude top level.
// An interior pixel's result is offered after its beat passes the shift,
// start and root states. A new pixel is accepted only when the last one is
// done, output stall included; the bit-serial root (one bit a cycle) dominates.
// Reset: asynchronous, active low; clears counters, window and registers
// to 640 by 480. Line buffers are not cleared.
`timescale 1ns / 1ps
module sobel_gradient_magnitude_3x3 #(
  parameter int unsigned MAX_WIDTH = sgm_pkg::MaxWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sgm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sgm_pkg::CfgW-1:0]   cfg_data_i,
  sgm_pix_if.sink                    pix_in,
  sgm_res_if.source                  res_out
);
  import sgm_pkg::*;
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [CfgW-1:0] width_q, height_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t res;
  logic [AW-1:0] addr;
  pix_t pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth:  width_q <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pix = '{red: pix_in.red, green: pix_in.green, blue: pix_in.blue};

  sgm_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk_i, .rst_ni, .width_i(width_q), .height_i(height_q),
    .in_valid_i(pix_in.valid), .in_ready_o(pix_in.ready),
    .out_valid_o(res_out.valid), .out_ready_i(res_out.ready),
    .addr_o(addr), .cmd_o(cmd), .sts_i(sts)
  );

  sgm_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .addr_i(addr), .pix_i(pix),
    .sts_o(sts), .res_o(res)
  );

  assign res_out.grad_x_blue  = res.grad_x_blue;
  assign res_out.grad_x_green = res.grad_x_green;
  assign res_out.grad_x_red   = res.grad_x_red;
  assign res_out.grad_y_blue  = res.grad_y_blue;
  assign res_out.grad_y_green = res.grad_y_green;
  assign res_out.grad_y_red   = res.grad_y_red;
  assign res_out.mag_blue     = res.mag_blue;
  assign res_out.mag_green    = res.mag_green;
  assign res_out.mag_red      = res.mag_red;
  assign res_out.frame_last   = res.frame_last;

  // A pixel beat and a result beat never coincide.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pix_in.valid && pix_in.ready && res_out.valid)) else $error("overlap");
  // A result is only offered for an interior pixel.
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid |-> cmd.emit) else $error("border result");
  // An offered result holds until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid && !res_out.ready |=> res_out.valid && $stable(res.mag_red))
    else $error("result dropped");
endmodule

// ===== sim/sgm_tb_scoreboard.sv =====
// Scoreboard class: pixel-stream predictor for the Sobel block and result checker.
`timescale 1ns / 1ps
class sobel_scoreboard;
  int unsigned width_reg;
  int unsigned height_reg;
  sgm_pkg::pix_t upper_line[sgm_pkg::MaxWidth];
  sgm_pkg::pix_t middle_line[sgm_pkg::MaxWidth];
  sgm_pkg::pix_t win[3][3];
  int unsigned col;
  int unsigned row;
  sgm_pkg::res_t expected_q[$];
  int mismatches;

  function new();
    width_reg = sgm_pkg::WidthReset;
    height_reg = sgm_pkg::HeightReset;
    col = 0;
    row = 0;
    mismatches = 0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;
  endfunction

  function void write_reg(logic [sgm_pkg::CfgIdxW-1:0] idx, int unsigned value);
    if (idx == sgm_pkg::RegWidth) width_reg = value & 12'hfff;
    else if (idx == sgm_pkg::RegHeight) height_reg = value & 12'hfff;
  endfunction

  function int chan(sgm_pkg::pix_t p, int k);
    case (k)
      0: return p.blue;
      1: return p.green;
      default: return p.red;
    endcase
  endfunction

  function int root_sat(int v);
    int root;
    int t;
    if (v >= 65536) return 255;
    root = 0;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = root | b;
      if (t * t <= v) root = t;
    end
    return root;
  endfunction

  // Advances the window by one accepted pixel and queues the gradient of
  // the interior pixel it completes, if any.
  function void note_pixel(sgm_pkg::pix_t p);
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    bit last_col;
    bit last_row;
    int gx;
    int gy;
    int qx;
    int qy;
    int m;
    sgm_pkg::res_t res;
    w = width_reg < 3 ? 3 : (width_reg > sgm_pkg::MaxWidth ? sgm_pkg::MaxWidth : width_reg);
    h = height_reg < 3 ? 3 : height_reg;
    idx = col % sgm_pkg::MaxWidth;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_line[idx];
    win[1][2] = middle_line[idx];
    win[2][2] = p;
    upper_line[idx] = middle_line[idx];
    middle_line[idx] = p;
    last_col = col >= w - 1;
    last_row = row >= h - 1;
    if (row >= 2 && col >= 2) begin
      res = '0;
      for (int k = 0; k < 3; k++) begin
        gx = 0;
        gy = 0;
        for (int r = 0; r < 3; r++)
          gx += (r == 1 ? 2 : 1) * (chan(win[r][0], k) - chan(win[r][2], k));
        for (int c = 0; c < 3; c++)
          gy += (c == 1 ? 2 : 1) * (chan(win[2][c], k) - chan(win[0][c], k));
        qx = gx / 4;
        qy = gy / 4;
        m = root_sat(qx * qx + qy * qy);
        case (k)
          0: begin
            res.grad_x_blue = 9'(qx);
            res.grad_y_blue = 9'(qy);
            res.mag_blue = 8'(m);
          end
          1: begin
            res.grad_x_green = 9'(qx);
            res.grad_y_green = 9'(qy);
            res.mag_green = 8'(m);
          end
          default: begin
            res.grad_x_red = 9'(qx);
            res.grad_y_red = 9'(qy);
            res.mag_red = 8'(m);
          end
        endcase
      end
      res.frame_last = last_col && last_row;
      expected_q = {expected_q, res};
    end
    if (last_col) begin
      col = 0;
      row = last_row ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function void check(sgm_pkg::res_t got);
    sgm_pkg::res_t exp_res;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result beat: %p", got);
      return;
    end
    exp_res = expected_q.pop_front();
    if (got !== exp_res) begin
      mismatches++;
      if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_res, got);
    end
  endfunction
endclass

// ===== sim/tb.sv =====
// Top-level testbench for the Sobel gradient magnitude block.
`timescale 1ns / 1ps
module tb;
  import sgm_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;
  bit no_idle;
  int stall;
  int sent_pixels;
  sobel_scoreboard sb;

  sgm_pix_if pix ();
  sgm_res_if res ();

  sobel_gradient_magnitude_3x3 u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_in(pix),
    .res_out(res)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Result side: random backpressure, sampled beats go to the checker.
  initial begin
    res.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        res.ready = 1'b0;
        stall--;
      end else begin
        res.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      sb.check('{res.grad_x_blue, res.grad_x_green, res.grad_x_red, res.grad_y_blue,
                 res.grad_y_green, res.grad_y_red, res.mag_blue, res.mag_green,
                 res.mag_red, res.frame_last});
    end
  end

  // Pixel patterns: 0 random, 1 saturated channels, 2 smooth, 3 horizontal
  // step, 4 vertical step, 5 mixed steps per channel.
  function automatic pix_t make_pixel(int style);
    pix_t p;
    int b;
    p = 24'($urandom);
    case (style)
      1: p = {$urandom_range(0, 1) ? 8'hff : 8'h00, $urandom_range(0, 1) ? 8'hff : 8'h00,
              $urandom_range(0, 1) ? 8'hff : 8'h00};
      2: begin
        b = 100 + sb.col % 7 * 3 + sb.row % 5;
        p = {8'(b + $urandom_range(0, 3)), 8'(b), 8'(b - $urandom_range(0, 3))};
      end
      3: p = sb.col == 0 ? 24'hffffff : (sb.col == 1 ? 24'h808080 : 24'h000000);
      4: p = sb.row == 0 ? 24'h000000 : (sb.row == 1 ? 24'h7f7f7f : 24'hffffff);
      5: begin
        p.blue = sb.col == 0 ? 8'h00 : 8'hff;
        p.green = sb.row == 0 ? 8'hff : 8'h00;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pixel(pix_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid = 1'b1;
    {pix.red, pix.green, pix.blue} = p;
    do @(posedge clk_i); while (!pix.ready);
    sb.note_pixel(p);
    sent_pixels++;
    @(negedge clk_i);
    pix.valid = 1'b0;
  endtask

  task automatic send_pixels(int count, int style);
    repeat (count) send_pixel(make_pixel(style));
  endtask

  // Sends until the frame position wraps back to the first pixel.
  task automatic finish_frame(int style);
    do send_pixel(make_pixel(style)); while (!(sb.col == 0 && sb.row == 0));
  endtask

  // Border pixels give no beat, so extra cycles cover work still in flight.
  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = CfgW'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, value);
  endtask

  initial begin
    int w;
    int h;
    sb = new();
    sent_pixels = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegWidth;
    cfg_data_i = '0;
    pix.valid = 1'b0;
    {pix.red, pix.green, pix.blue} = '0;
    no_idle = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_reg(RegWidth, 3);
    write_reg(RegHeight, 3);
    finish_frame(3);
    finish_frame(4);
    finish_frame(5);
    finish_frame(1);
    wait_idle();

    // Register values below the minimum are raised to three.
    write_reg(RegWidth, 1);
    write_reg(RegHeight, 0);
    finish_frame(0);
    wait_idle();

    // Narrowing the frame mid-row: the column counter is past the new end.
    write_reg(RegWidth, 8);
    write_reg(RegHeight, 6);
    send_pixels(21, 0);
    wait_idle();
    write_reg(RegWidth, 4);
    finish_frame(0);
    finish_frame(0);
    wait_idle();

    // Lowering the height while the row counter is past the new last row.
    write_reg(RegWidth, 5);
    write_reg(RegHeight, 7);
    send_pixels(26, 0);
    wait_idle();
    write_reg(RegHeight, 4);
    finish_frame(0);
    wait_idle();

    // Oversized width and height, cut short by narrowing mid-frame.
    no_idle = 1'b1;
    write_reg(RegWidth, 4095);
    write_reg(RegHeight, 3);
    send_pixels(20, 0);
    wait_idle();
    write_reg(RegWidth, 3);
    finish_frame(0);
    wait_idle();
    write_reg(RegHeight, 4095);
    send_pixels(30, 2);
    wait_idle();
    write_reg(RegHeight, 3);
    finish_frame(2);
    wait_idle();
    no_idle = 1'b0;

    sent_pixels = 0;
    while (sent_pixels < 500) begin
      w = $urandom_range(0, 9) == 0 ? $urandom_range(17, 32) : $urandom_range(3, 16);
      h = $urandom_range(3, 10);
      no_idle = $urandom_range(0, 4) == 0;
      write_reg(RegWidth, w);
      write_reg(RegHeight, h);
      repeat ($urandom_range(1, 2)) finish_frame($urandom_range(0, 2));
      wait_idle();
    end
    no_idle = 1'b0;

    repeat (40) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
